>>> rtl/core/tlp_pkg.sv
`default_nettype none

package tlp_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_NUM  = 2'd1,
        PH_SPAN = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    // result token kinds
    typedef enum logic [2:0] {
        TK_INT  = 3'd0,
        TK_HDR  = 3'd1,
        TK_BYTE = 3'd2,
        TK_END  = 3'd3,
        TK_ERR  = 3'd4
    } t_tok_kind;

    // input word kinds
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    // characters of the encoding
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // one accepted input word
    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } t_in_word;

    // one result word
    typedef struct packed {
        t_tok_kind   token_kind;
        logic [7:0]  tag;
        logic [31:0] value;
        logic [7:0]  data_byte;
        logic        last_of_span;
    } t_result;

    // output stage status towards the parser
    typedef struct packed {
        logic can_take;
        logic end_pending;
    } t_out_status;

    localparam t_result END_RESULT = '{
        token_kind:   TK_END,
        tag:          8'h00,
        value:        32'h0,
        data_byte:    8'h00,
        last_of_span: 1'b0
    };

endpackage

`default_nettype wire

>>> rtl/core/tlp_in_stage.sv
`default_nettype none

module tlp_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tlp_pkg::t_in_word i_word,
    input  wire logic              i_take,
    output logic                   o_valid,
    output tlp_pkg::t_in_word      o_word
);
    import tlp_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // space when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // held word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tlp_parse.sv
`default_nettype none

module tlp_parse #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire tlp_pkg::t_in_word i_word,
    output logic                   o_has_res,
    output logic                   o_pend_end,
    output tlp_pkg::t_result       o_res
);
    import tlp_pkg::*;

    localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int MUL_BITS = VALUE_BITS + 4;

    t_phase                  r_phase, n_phase;
    logic [7:0]              r_tag, n_tag;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic                    r_digits, n_digits;
    logic [VALUE_BITS-2:0]   r_rem, n_rem;

    logic                    is_end;
    logic [7:0]              c;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [MUL_BITS-1:0]     mag10;
    logic [MUL_BITS-1:0]     limit;
    logic                    ovf;
    logic                    minus_ok;
    logic                    tag_int;
    logic                    tag_span;
    logic                    span_ok;
    logic                    close_err;
    logic [VALUE_BITS-2:0]   hdr_rem;
    logic [VALUE_BITS-2:0]   rem_dec;
    logic [EXT_BITS-1:0]     int_ext;
    logic [EXT_BITS-1:0]     hdr_ext;

    // decode of the current word
    assign is_end   = (i_word.kind == IN_END);
    assign c        = i_word.char_byte;
    assign is_digit = (c inside {[CH_0:CH_9]});
    assign digit    = 4'(c - CH_0);
    assign minus_ok = (c == CH_MINUS) && !r_digits && !r_neg;

    // next decimal step and range check: mag*10 + d must not pass the limit
    assign mag10 = MUL_BITS'({r_mag, 3'b000}) + MUL_BITS'({r_mag, 1'b0})
                 + MUL_BITS'(digit);
    assign limit = r_neg ? (MUL_BITS'(1) << (VALUE_BITS - 1))
                         : ((MUL_BITS'(1) << (VALUE_BITS - 1)) - MUL_BITS'(1));
    assign ovf   = (mag10 > limit);

    // number close checks
    assign tag_int   = (r_tag == CH_USCORE) || (r_tag inside {[CH_LA:CH_LZ]});
    assign tag_span  = (r_tag inside {[CH_UA:CH_UZ]});
    assign span_ok   = tag_span && !r_neg && (r_mag != '0) && !is_end && (c == CH_BANG);
    assign close_err = !r_digits || (!tag_int && !span_ok);

    // span length without the escape, and countdown
    assign hdr_rem = r_mag[VALUE_BITS-2:0] - {{(VALUE_BITS-2){1'b0}}, 1'b1};
    assign rem_dec = r_rem - {{(VALUE_BITS-2){1'b0}}, 1'b1};

    // signed token value and header length, widened before the low word is taken
    assign int_ext = r_neg ? (EXT_BITS'(0) - EXT_BITS'(r_mag)) : EXT_BITS'(r_mag);
    assign hdr_ext = EXT_BITS'(hdr_rem);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_NUM: begin
                if (is_end) begin
                    n_phase = PH_TAG;
                end else if (is_digit) begin
                    n_phase = ovf ? PH_DROP : PH_NUM;
                end else if (minus_ok) begin
                    n_phase = PH_NUM;
                end else if (close_err) begin
                    n_phase = PH_DROP;
                end else if (tag_int) begin
                    n_phase = PH_NUM;
                end else begin
                    n_phase = (hdr_rem != '0) ? PH_SPAN : PH_TAG;
                end
            end
            PH_SPAN: begin
                if (is_end || (rem_dec == '0)) begin
                    n_phase = PH_TAG;
                end
            end
            PH_DROP: begin
                if (is_end) begin
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                n_phase = is_end ? PH_TAG : PH_NUM;
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    // results and running number state
    always_comb begin
        n_tag      = r_tag;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_digits   = r_digits;
        n_rem      = r_rem;
        o_has_res  = 1'b0;
        o_pend_end = 1'b0;
        o_res      = '{token_kind: TK_ERR, tag: r_tag, value: 32'h0,
                       data_byte: 8'h00, last_of_span: 1'b0};
        case (r_phase)
            PH_NUM: begin
                if (!is_end && is_digit) begin
                    if (ovf) begin
                        o_has_res = 1'b1;
                        n_mag     = '0;
                        n_neg     = 1'b0;
                        n_digits  = 1'b0;
                    end else begin
                        n_mag    = mag10[VALUE_BITS-1:0];
                        n_digits = 1'b1;
                    end
                end else if (!is_end && minus_ok) begin
                    n_neg = 1'b1;
                end else begin
                    // the number closes here
                    o_has_res = 1'b1;
                    n_mag     = '0;
                    n_neg     = 1'b0;
                    n_digits  = 1'b0;
                    if (close_err) begin
                        o_res.token_kind = TK_ERR;
                    end else if (tag_int) begin
                        o_res.token_kind = TK_INT;
                        o_res.value      = int_ext[31:0];
                        o_pend_end       = is_end;
                        if (!is_end) begin
                            n_tag = c;
                        end
                    end else begin
                        o_res.token_kind   = TK_HDR;
                        o_res.value        = hdr_ext[31:0];
                        o_res.last_of_span = (hdr_rem == '0);
                        n_rem              = hdr_rem;
                    end
                end
            end
            PH_SPAN: begin
                o_has_res = 1'b1;
                if (is_end) begin
                    o_res.token_kind = TK_ERR;
                    n_rem            = '0;
                end else begin
                    o_res.token_kind   = TK_BYTE;
                    o_res.data_byte    = c;
                    o_res.last_of_span = (rem_dec == '0);
                    n_rem              = rem_dec;
                end
            end
            PH_DROP: begin
                o_has_res = 1'b0;
            end
            PH_TAG: begin
                if (is_end) begin
                    o_has_res = 1'b1;
                    o_res     = END_RESULT;
                end else begin
                    n_tag    = c;
                    n_mag    = '0;
                    n_neg    = 1'b0;
                    n_digits = 1'b0;
                end
            end
            default: begin
                o_has_res = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_tag    <= '0;
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_digits <= 1'b0;
            r_rem    <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_digits <= n_digits;
            r_rem    <= n_rem;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tlp_out_stage.sv
`default_nettype none

module tlp_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_pend_end,
    input  wire tlp_pkg::t_result i_res,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output tlp_pkg::t_result      o_res,
    output tlp_pkg::t_out_status  o_status
);
    import tlp_pkg::*;

    logic    r_valid;
    logic    r_pend;
    t_result r_res;

    // a new result fits when the slot is empty or leaves with nothing queued behind it
    assign o_status.can_take    = !r_valid || (i_ready && !r_pend);
    assign o_status.end_pending = r_pend;
    assign o_valid              = r_valid;
    assign o_res                = r_res;

    // slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pend  <= i_pend_end;
        end else if (r_valid && i_ready) begin
            r_valid <= r_pend;
            r_pend  <= 1'b0;
        end
    end

    // result word, end of string follows a closing integer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (r_valid && i_ready && r_pend) begin
            r_res <= END_RESULT;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tag_length_token_parser.sv
// Tag-length token parser.
// Slave stream: one word per character; tuser = 0 carries a byte in tdata[7:0],
// tuser = 1 closes the encoded string (tdata ignored).
// Master stream: one word per token; tuser = token kind (integer, span header,
// span byte, end of string, error), tlast = last byte of a span or header of an
// empty span, tdata = tag, signed value and span byte.
// A result passes through the input register and then the output register after
// its input word is accepted. Throughput is one input word per cycle while the
// receiver keeps up; an integer closed by the end word yields two results from
// the one output register and so holds the parser until the integer is taken.
// An input register and an output register with a queued end-of-string flag
// separate the two sides; while the receiver stalls, one more input word is
// held, then tready drops.
// Reset (synchronous, active low) empties both registers and returns the parser
// to waiting for a tag. After an error the rest of the string is dropped.
`default_nettype none

module tag_length_token_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // char_byte[7:0]
    input  wire logic        i_s_axis_tuser,   // kind[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // tag[7:0], value[39:8], data_byte[47:40]
    output logic [2:0]       o_m_axis_tuser,   // token_kind[2:0]
    output logic             o_m_axis_tlast
);
    import tlp_pkg::*;

    t_in_word    s_word;
    t_in_word    held_word;
    logic        held_valid;
    logic        fire;
    logic        has_res;
    logic        pend_end;
    t_result     res;
    t_result     out_res;
    t_out_status out_st;

    assign s_word.kind      = i_s_axis_tuser;
    assign s_word.char_byte = i_s_axis_tdata;

    // the held word is parsed when the output slot can take its results
    assign fire = held_valid && out_st.can_take;

    tlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (s_word),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    tlp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_word     (held_word),
        .o_has_res  (has_res),
        .o_pend_end (pend_end),
        .o_res      (res)
    );

    tlp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && has_res),
        .i_pend_end (pend_end),
        .i_res      (res),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (out_res),
        .o_status   (out_st)
    );

    // master word packing
    assign o_m_axis_tdata = {out_res.data_byte, out_res.value, out_res.tag};
    assign o_m_axis_tuser = out_res.token_kind;
    assign o_m_axis_tlast = out_res.last_of_span;

    // a queued end of string only sits behind an integer token
    a_pend_int : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_st.end_pending |-> (o_m_axis_tvalid && (o_m_axis_tuser == TK_INT)))
        else $error("end of string queued behind a non-integer result");

    // parsing never overwrites a result the receiver has not taken
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && has_res) |-> (!o_m_axis_tvalid || (i_m_axis_tready && !out_st.end_pending)))
        else $error("result loaded over a waiting result");

    // an integer with a queued end is followed by the end of string once taken
    a_end_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_st.end_pending && i_m_axis_tready) |=>
            (o_m_axis_tvalid && (o_m_axis_tuser == TK_END)))
        else $error("queued end of string lost");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlp_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_WORDS = 1150;

    // running token prediction and the queue of tokens still owed by the block
    class token_scoreboard;
        t_phase      phase;
        logic [7:0]  cur_tag;
        logic [63:0] magnitude;
        logic        negative;
        logic        have_digit;
        logic [30:0] span_left;
        t_result     expected_q[$];
        int          errors;

        function new();
            phase = PH_TAG;
            cur_tag = '0;
            span_left = '0;
            errors = 0;
            clear_number();
        endfunction

        function void clear_number();
            magnitude = '0;
            negative = 1'b0;
            have_digit = 1'b0;
        endfunction

        function void push_token(t_tok_kind kind, logic [7:0] tag, logic [31:0] value,
                                 logic [7:0] data, logic last);
            t_result r;
            r.token_kind = kind;
            r.tag = tag;
            r.value = value;
            r.data_byte = data;
            r.last_of_span = last;
            expected_q = {expected_q, r};
        endfunction

        // error token; with a byte in hand the rest of the string is dropped
        function void raise_fault(bit have_byte);
            push_token(TK_ERR, cur_tag, '0, '0, 1'b0);
            phase = have_byte ? PH_DROP : PH_TAG;
            clear_number();
        endfunction

        // number finished by a non-digit byte or by the end word
        function void close_number(bit have_byte, logic [7:0] c);
            logic [63:0] content;
            if (!have_digit) begin
                raise_fault(have_byte);
            end else if (cur_tag == CH_USCORE || (cur_tag >= CH_LA && cur_tag <= CH_LZ)) begin
                push_token(TK_INT, cur_tag,
                           negative ? 32'(64'd0 - magnitude) : magnitude[31:0], '0, 1'b0);
                clear_number();
                if (have_byte) begin
                    cur_tag = c;
                    phase = PH_NUM;
                end else begin
                    push_token(TK_END, '0, '0, '0, 1'b0);
                    phase = PH_TAG;
                end
            end else if (cur_tag >= CH_UA && cur_tag <= CH_UZ) begin
                if (negative || magnitude == 0 || !have_byte || c != CH_BANG) begin
                    raise_fault(have_byte);
                end else begin
                    content = magnitude - 64'd1;
                    push_token(TK_HDR, cur_tag, content[31:0], '0, content == 0);
                    span_left = content[30:0];
                    clear_number();
                    phase = (content == 0) ? PH_TAG : PH_SPAN;
                end
            end else begin
                raise_fault(have_byte);
            end
        endfunction

        // advance the parser by one accepted input word
        function void note_word(logic kind, logic [7:0] c);
            logic [63:0] digit;
            logic [63:0] limit;
            case (phase)
                PH_NUM: begin
                    if (kind == IN_END) begin
                        close_number(1'b0, '0);
                    end else if (c >= CH_0 && c <= CH_9) begin
                        digit = 64'(c - CH_0);
                        limit = (64'd1 << (VALUE_BITS - 1)) - (negative ? 64'd0 : 64'd1);
                        if (magnitude > (limit - digit) / 64'd10) begin
                            raise_fault(1'b1);
                        end else begin
                            magnitude = magnitude * 64'd10 + digit;
                            have_digit = 1'b1;
                        end
                    end else if (c == CH_MINUS && !have_digit && !negative) begin
                        negative = 1'b1;
                    end else begin
                        close_number(1'b1, c);
                    end
                end
                PH_SPAN: begin
                    if (kind == IN_END) begin
                        span_left = '0;
                        raise_fault(1'b0);
                    end else begin
                        span_left = span_left - 31'd1;
                        push_token(TK_BYTE, cur_tag, '0, c, span_left == 0);
                        if (span_left == 0) begin
                            phase = PH_TAG;
                        end
                    end
                end
                PH_DROP: begin
                    if (kind == IN_END) begin
                        phase = PH_TAG;
                    end
                end
                default: begin
                    if (kind == IN_END) begin
                        push_token(TK_END, '0, '0, '0, 1'b0);
                        phase = PH_TAG;
                    end else begin
                        cur_tag = c;
                        clear_number();
                        phase = PH_NUM;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
            end
        endfunction

        // compare one output word against the oldest owed token
        function void check_result(t_result seen);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none got kind %0d tag %0h value %0h",
                         $time, seen.token_kind, seen.tag, seen.value);
                return;
            end
            want = expected_q.pop_front();
            compare_field("token_kind", 32'(want.token_kind), 32'(seen.token_kind));
            compare_field("tag", 32'(want.tag), 32'(seen.tag));
            compare_field("value", want.value, seen.value);
            compare_field("data_byte", 32'(want.data_byte), 32'(seen.data_byte));
            compare_field("last_of_span", 32'(want.last_of_span), 32'(seen.last_of_span));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // char_byte[7:0]
    logic        i_s_axis_tuser = 1'b0;    // kind[0]
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;           // tag[7:0], value[39:8], data_byte[47:40]
    logic [2:0]  o_m_axis_tuser;           // token_kind[2:0]
    logic        o_m_axis_tlast;

    token_scoreboard sb;
    logic [7:0]      text_q[$];
    int              words_sent = 0;
    int              s_gap_max = 7;
    int              m_stall_max = 7;
    int              cycles = 0;

    tag_length_token_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL tag_length_token_parser");
            $finish;
        end
    end

    // observe words on both sides
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && sb != null) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.token_kind = t_tok_kind'(o_m_axis_tuser);
                seen.tag = o_m_axis_tdata[7:0];
                seen.value = o_m_axis_tdata[39:8];
                seen.data_byte = o_m_axis_tdata[47:40];
                seen.last_of_span = o_m_axis_tlast;
                sb.check_result(seen);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_word(i_s_axis_tuser, i_s_axis_tdata);
            end
        end
    end

    // receiver with random stalls before each word
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, m_stall_max);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    task automatic send_word(input logic kind, input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= c;
        i_s_axis_tuser <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        words_sent++;
    endtask

    // the collected bytes, then the end word
    task automatic send_text();
        foreach (text_q[i]) begin
            send_word(IN_BYTE, text_q[i]);
        end
        send_word(IN_END, 8'($urandom));
        text_q = {};
    endtask

    // one more byte at the tail of the string being built
    function automatic void append_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            append_byte(s[i]);
        end
    endfunction

    function automatic void add_decimal(longint unsigned mag);
        logic [7:0] digits[$];
        do begin
            digits.push_front(CH_0 + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digits[i]) begin
            append_byte(digits[i]);
        end
    endfunction

    // integer component, extremes and overflow included
    function automatic void add_int();
        longint unsigned mag;
        append_byte(($urandom_range(0, 7) == 0) ? CH_USCORE
                                                : CH_LA + 8'($urandom_range(0, 25)));
        if ($urandom_range(0, 2) == 0) begin
            append_byte(CH_MINUS);
        end
        case ($urandom_range(0, 5))
            0: mag = $urandom_range(0, 9);
            1: mag = $urandom_range(0, 99999);
            2: mag = $urandom;
            3: mag = 64'd2147483647 + $urandom_range(0, 1);
            4: mag = 64'd99999999999;
            default: begin
                // leading zero
                append_byte(CH_0);
                mag = $urandom_range(0, 999);
            end
        endcase
        add_decimal(mag);
    endfunction

    // span component; returns 1 when the string has to end right after it
    function automatic bit add_span();
        int n;
        n = -1;
        append_byte(CH_UA + 8'($urandom_range(0, 25)));
        case ($urandom_range(0, 11))
            0: begin
                // small, zero or negative length
                if ($urandom_range(0, 1) == 1) begin
                    append_byte(CH_MINUS);
                end
                add_decimal($urandom_range(0, 3));
                append_byte(CH_BANG);
            end
            1: begin
                // header promises more than the string holds
                add_decimal(($urandom_range(0, 1) == 1) ? 64'd2147483647
                                                        : 64'($urandom_range(3, 9)));
                append_byte(CH_BANG);
                repeat ($urandom_range(0, 1)) append_byte(8'($urandom));
                return 1'b1;
            end
            2: begin
                // no escape
                add_decimal($urandom_range(1, 5));
                append_byte(8'($urandom));
            end
            3: begin
                add_decimal($urandom_range(1, 5));
                return 1'b1;
            end
            4: n = $urandom_range(7, 40);
            default: n = $urandom_range(0, 6);
        endcase
        if (n >= 0) begin
            add_decimal(n + 1);
            append_byte(CH_BANG);
            repeat (n) append_byte(8'($urandom));
        end
        return 1'b0;
    endfunction

    function automatic void add_noise();
        case ($urandom_range(0, 3))
            0: append_byte(CH_LA + 8'($urandom_range(0, 25)));
            1: begin
                append_byte(8'($urandom));
                add_decimal($urandom_range(0, 99));
            end
            2: begin
                // second minus
                append_byte(CH_LA);
                append_byte(CH_MINUS);
                append_byte(CH_MINUS);
                add_decimal(7);
            end
            default: repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        endcase
    endfunction

    function automatic void build_string();
        int parts;
        int pick;
        parts = $urandom_range(0, 4);
        for (int k = 0; k < parts; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                add_int();
            end else if (pick < 85) begin
                if (add_span()) break;
            end else begin
                add_noise();
            end
        end
    endfunction

    // main sequence
    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty string
        send_text();
        // empty span, span with extreme bytes, negative zero closed by the end word
        add_text("A1!B3!");
        append_byte(8'hFF);
        append_byte(8'h00);
        add_text("a-0");
        send_text();
        // bad tag
        add_text("{5");
        send_text();
        // lone minus
        add_text("a-");
        send_text();
        // missing escape
        add_text("C2x");
        send_text();
        // span cut short by the end word
        add_text("D9!ab");
        send_text();
        // negative span length, rest dropped
        add_text("Z-1!k");
        send_text();

        // random strings with changing idle patterns
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 5) == 0) begin
                s_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                m_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            end
            build_string();
            send_text();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS tag_length_token_parser");
        end else begin
            $display("FAIL tag_length_token_parser");
        end
        $finish;
    end

endmodule

`default_nettype wire
